// File: rtl/rigid_transform_orthogonalizer_top_macros.svh
// Assertion macros for the orthogonalizer top level
`ifndef RIGID_TRANSFORM_ORTHOGONALIZER_TOP_MACROS_SVH
`define RIGID_TRANSFORM_ORTHOGONALIZER_TOP_MACROS_SVH

// same-cycle implication
`define RTO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define RTO_ASSERT_LAT(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) else $error(msg);

`endif

// File: rtl/rto_pkg.sv
// Shared types, constants and tables for the orthogonalizer
package rto_pkg;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int LANES          = 6;
   localparam int CORDIC_STEPS   = 31;
   localparam int CW             = 34;   // CORDIC datapath width
   localparam int VW             = 32;   // normalized vector width
   localparam int MAG_W          = 33;   // magnitude width
   localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic [29:0] KINV_Q30 = 30'd652032874;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_SCALE = 2'd1;
   localparam logic [1:0] ERR_DET   = 2'd2;

   typedef struct packed {
      logic       vld;
      logic [1:0] err;
   } ctl_type;

   // atan(2^-i) in Q0.30; below 2^-10 it equals 2^-i at this precision
   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] r;
      r = 30'd1;
      case (idx)
         0: r = 30'd843314857;
         1: r = 30'd497837829;
         2: r = 30'd263043837;
         3: r = 30'd133525159;
         4: r = 30'd67021687;
         5: r = 30'd33543516;
         6: r = 30'd16775851;
         7: r = 30'd8388437;
         8: r = 30'd4194283;
         9: r = 30'd2097149;
         default: r = (idx <= 30) ? (30'd1 << (30 - idx)) : 30'd0;
      endcase
      return r;
   endfunction
endpackage

// File: rtl/rigid_transform_orthogonalizer_top.sv
// Throughput: one item per cycle; busy is always low, nothing stalls.
// The latency comes mostly from the bit-per-stage element divider (WORD_WIDTH+FRAC_BITS
// stages), the 31-stage CORDIC and the FRAC_BITS+2 stage cos/sin divider.
// Reset clears all valid bits in the pipeline; data registers are not reset.
// Each result shows on the rsp_ ports for one cycle with rsp_valid high.
`include "rigid_transform_orthogonalizer_top_macros.svh"

module rigid_transform_orthogonalizer_top import rto_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [WORD_WIDTH-1:0]  req_m00,
   input  logic signed [WORD_WIDTH-1:0]  req_m01,
   input  logic signed [WORD_WIDTH-1:0]  req_m02,
   input  logic signed [WORD_WIDTH-1:0]  req_m10,
   input  logic signed [WORD_WIDTH-1:0]  req_m11,
   input  logic signed [WORD_WIDTH-1:0]  req_m12,
   input  logic signed [WORD_WIDTH-1:0]  req_scale_elem,
   output logic                          rsp_valid,
   output logic signed [FRAC_BITS+1:0]   rsp_cos_out,
   output logic signed [FRAC_BITS+1:0]   rsp_sin_out,
   output logic signed [WORD_WIDTH-1:0]  rsp_tx_out,
   output logic signed [WORD_WIDTH-1:0]  rsp_ty_out,
   output logic signed [FRAC_BITS+2:0]   rsp_angle_out,
   output logic [1:0]                    rsp_error_code
);
   localparam int LAT = WORD_WIDTH + 2 * FRAC_BITS + 47;
   localparam logic signed [FRAC_BITS+1:0] ONE_Q = (FRAC_BITS+2)'(1) << FRAC_BITS;

   // fully pipelined: an item may enter every cycle
   assign busy = 1'b0;

   ctl_type                          in_ctl;
   logic [LANES-1:0][WORD_WIDTH-1:0] in_e;

   // element order: m00 m01 m02 m10 m11 m12
   always_comb begin
      in_ctl.vld = start && !busy;
      in_ctl.err = (req_scale_elem == '0) ? ERR_SCALE : ERR_OK;
      in_e[0]    = req_m00;
      in_e[1]    = req_m01;
      in_e[2]    = req_m02;
      in_e[3]    = req_m10;
      in_e[4]    = req_m11;
      in_e[5]    = req_m12;
   end

   // divide all six elements by the scale
   ctl_type                          div_ctl;
   logic [LANES-1:0][WORD_WIDTH-1:0] div_q;

   rto_div #(.W(WORD_WIDTH), .F(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (in_ctl),
      .in_e     (in_e),
      .in_scale (req_scale_elem),
      .out_ctl  (div_ctl),
      .out_q    (div_q)
   );

   // determinant check, v0 = m00+m11, v1 = m10-m01, normalize to [2^30, 2^31)
   ctl_type                norm_ctl;
   logic signed [VW-1:0]   norm_x0, norm_y0;
   logic                   norm_mz;
   logic [WORD_WIDTH-1:0]  norm_tx, norm_ty;

   rto_norm #(.W(WORD_WIDTH)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (div_ctl),
      .in_e      (div_q),
      .out_ctl   (norm_ctl),
      .out_x0    (norm_x0),
      .out_y0    (norm_y0),
      .out_mzero (norm_mz),
      .out_tx    (norm_tx),
      .out_ty    (norm_ty)
   );

   // vectoring: x ends as gain-scaled magnitude, z as the angle in Q30
   ctl_type                cor_ctl;
   logic signed [CW-1:0]   cor_x, cor_z;
   logic signed [VW-1:0]   cor_x0, cor_y0;
   logic                   cor_mz;
   logic [WORD_WIDTH-1:0]  cor_tx, cor_ty;

   rto_cordic #(.W(WORD_WIDTH)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (norm_ctl),
      .in_x0     (norm_x0),
      .in_y0     (norm_y0),
      .in_mzero  (norm_mz),
      .in_tx     (norm_tx),
      .in_ty     (norm_ty),
      .out_ctl   (cor_ctl),
      .out_x     (cor_x),
      .out_z     (cor_z),
      .out_x0    (cor_x0),
      .out_y0    (cor_y0),
      .out_mzero (cor_mz),
      .out_tx    (cor_tx),
      .out_ty    (cor_ty)
   );

   // cos = v0/|v|, sin = v1/|v|, angle rounding; outputs come from registers here
   ctl_type out_ctl;

   rto_ratio #(.W(WORD_WIDTH), .F(FRAC_BITS)) u_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (cor_ctl),
      .in_x      (cor_x),
      .in_z      (cor_z),
      .in_x0     (cor_x0),
      .in_y0     (cor_y0),
      .in_mzero  (cor_mz),
      .in_tx     (cor_tx),
      .in_ty     (cor_ty),
      .out_ctl   (out_ctl),
      .out_cos   (rsp_cos_out),
      .out_sin   (rsp_sin_out),
      .out_tx    (rsp_tx_out),
      .out_ty    (rsp_ty_out),
      .out_angle (rsp_angle_out)
   );

   assign rsp_valid      = out_ctl.vld;
   assign rsp_error_code = out_ctl.err;

   `RTO_ASSERT_IMPL(a_scale_zero_blank, clock, reset, rsp_valid && rsp_error_code == ERR_SCALE, rsp_tx_out == '0 && rsp_ty_out == '0 && rsp_cos_out == '0 && rsp_sin_out == '0 && rsp_angle_out == '0, "scale zero result not blank")
   `RTO_ASSERT_IMPL(a_det_blank, clock, reset, rsp_valid && rsp_error_code == ERR_DET, rsp_cos_out == '0 && rsp_sin_out == '0 && rsp_angle_out == '0, "determinant error result not blank")
   `RTO_ASSERT_IMPL(a_unit_range, clock, reset, rsp_valid && rsp_error_code == ERR_OK, rsp_cos_out <= ONE_Q && rsp_cos_out >= -ONE_Q && rsp_sin_out <= ONE_Q && rsp_sin_out >= -ONE_Q, "cos or sin beyond unit")
   `RTO_ASSERT_LAT(a_latency, clock, reset, start && !busy, LAT, rsp_valid, "item lost in pipeline")
endmodule

// File: rtl/rto_div.sv
// Six-lane pipelined restoring divider: element * 2^F / scale, saturated
module rto_div import rto_pkg::*; #(
   parameter int W = WORD_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  in_ctl,
   input  logic [LANES-1:0][W-1:0]  in_e,
   input  logic [W-1:0]             in_scale,
   output ctl_type                  out_ctl,
   output logic [LANES-1:0][W-1:0]  out_q
);
   localparam int QW = W + F;
   localparam logic [QW-1:0] NEG_LIM = QW'(1) << (W - 1);
   localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

   ctl_type                   ctl_ff [QW+1];
   logic [W-1:0]              d_ff   [QW+1];
   logic [LANES-1:0]          neg_ff [QW+1];
   logic [LANES-1:0][QW-1:0]  nq_ff  [QW+1];
   logic [LANES-1:0][W-1:0]   rem_ff [QW+1];

   logic [W-1:0]              d0_in;
   logic [LANES-1:0]          neg0_in;
   logic [LANES-1:0][QW-1:0]  nq0_in;

   ctl_type                   octl_ff;
   logic [LANES-1:0][W-1:0]   q_ff, q_in;

   always_comb begin
      d0_in = in_scale[W-1] ? W'(-in_scale) : in_scale;
      for (int l = 0; l < LANES; l++) begin
         neg0_in[l] = in_e[l][W-1] ^ in_scale[W-1];
         nq0_in[l]  = {(in_e[l][W-1] ? W'(-in_e[l]) : in_e[l]), {F{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].vld <= 1'b0;
         ctl_ff[0].err <= ERR_OK;
      end else begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      d_ff[0]   <= d0_in;
      neg_ff[0] <= neg0_in;
      nq_ff[0]  <= nq0_in;
      rem_ff[0] <= '0;
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= QW; k++) begin : g_stg
      logic [LANES-1:0][W:0]    trial;
      logic [LANES-1:0][QW-1:0] nq_in;
      logic [LANES-1:0][W-1:0]  rem_in;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_ff[k-1][l], nq_ff[k-1][l][QW-1]};
            if (trial[l] >= {1'b0, d_ff[k-1]}) begin
               rem_in[l] = W'(trial[l] - {1'b0, d_ff[k-1]});
               nq_in[l]  = {nq_ff[k-1][l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][W-1:0];
               nq_in[l]  = {nq_ff[k-1][l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].vld <= 1'b0;
            ctl_ff[k].err <= ERR_OK;
         end else begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         d_ff[k]   <= d_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         nq_ff[k]  <= nq_in;
         rem_ff[k] <= rem_in;
      end
   end

   // sign and saturate
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (neg_ff[QW][l]) begin
            if (nq_ff[QW][l] > NEG_LIM) begin
               q_in[l] = {1'b1, {(W-1){1'b0}}};
            end else begin
               q_in[l] = W'(QW'(0) - nq_ff[QW][l]);
            end
         end else if (nq_ff[QW][l] > POS_LIM) begin
            q_in[l] = {1'b0, {(W-1){1'b1}}};
         end else begin
            q_in[l] = nq_ff[QW][l][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octl_ff.vld <= 1'b0;
         octl_ff.err <= ERR_OK;
      end else begin
         octl_ff <= ctl_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign out_ctl = octl_ff;
   assign out_q   = q_ff;
endmodule

// File: rtl/rto_norm.sv
// Determinant test, vector sum and staged power-of-two normalization
module rto_norm import rto_pkg::*; #(
   parameter int W = WORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  in_ctl,
   input  logic [LANES-1:0][W-1:0]  in_e,
   output ctl_type                  out_ctl,
   output logic signed [VW-1:0]     out_x0,
   output logic signed [VW-1:0]     out_y0,
   output logic                     out_mzero,
   output logic [W-1:0]             out_tx,
   output logic [W-1:0]             out_ty
);
   localparam int NW = (W + 1 > 31) ? W + 1 : 31;
   localparam int NS = 5;
   localparam logic [NW:0]   BIG_LIM = (NW+1)'(1) << 31;
   localparam logic [NW-1:0] LO_LIM  = NW'(1) << 30;

   // stage 1: products and sums
   ctl_type                ctl1_ff;
   logic signed [2*W-1:0]  p0_ff, p1_ff, p0_in, p1_in;
   logic [W:0]             x_ff, y_ff, x_in, y_in;
   logic [W-1:0]           tx1_ff, ty1_ff;
   logic signed [W-1:0]    e0s, e1s, e3s, e4s;

   always_comb begin
      e0s   = in_e[0];
      e1s   = in_e[1];
      e3s   = in_e[3];
      e4s   = in_e[4];
      p0_in = e0s * e4s;
      p1_in = e3s * e1s;
      x_in  = {in_e[0][W-1], in_e[0]} + {in_e[4][W-1], in_e[4]};
      y_in  = {in_e[3][W-1], in_e[3]} - {in_e[1][W-1], in_e[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.vld <= 1'b0;
         ctl1_ff.err <= ERR_OK;
      end else begin
         ctl1_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      tx1_ff <= in_e[2];
      ty1_ff <= in_e[5];
   end

   // stage 2 and shift stages
   ctl_type        nctl_ff [NS+1];
   logic [NW-1:0]  ax_ff   [NS+1];
   logic [NW-1:0]  ay_ff   [NS+1];
   logic [NW-1:0]  m_ff    [NS+1];
   logic           sx_ff   [NS+1];
   logic           sy_ff   [NS+1];
   logic           big_ff  [NS+1];
   logic [W-1:0]   ntx_ff  [NS+1];
   logic [W-1:0]   nty_ff  [NS+1];

   ctl_type        ctl2_in;
   logic [W:0]     xm, ym;
   logic [NW-1:0]  ax2_in, ay2_in, m2_in;

   always_comb begin
      ctl2_in = ctl1_ff;
      if (ctl1_ff.err == ERR_OK && !(p0_ff > p1_ff)) begin
         ctl2_in.err = ERR_DET;
      end
      xm     = x_ff[W] ? (W+1)'(0) - x_ff : x_ff;
      ym     = y_ff[W] ? (W+1)'(0) - y_ff : y_ff;
      ax2_in = NW'(xm);
      ay2_in = NW'(ym);
      m2_in  = (ax2_in > ay2_in) ? ax2_in : ay2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nctl_ff[0].vld <= 1'b0;
         nctl_ff[0].err <= ERR_OK;
      end else begin
         nctl_ff[0] <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff[0]  <= ax2_in;
      ay_ff[0]  <= ay2_in;
      m_ff[0]   <= m2_in;
      sx_ff[0]  <= x_ff[W];
      sy_ff[0]  <= y_ff[W];
      big_ff[0] <= ({1'b0, m2_in} >= BIG_LIM);
      ntx_ff[0] <= tx1_ff;
      nty_ff[0] <= ty1_ff;
   end

   // shift by 16, 8, 4, 2, 1: right while above range, left while below
   for (genvar j = 1; j <= NS; j++) begin : g_sh
      localparam int SH = 16 >> (j - 1);
      logic          take;
      logic [NW-1:0] ax_in, ay_in, m_in;

      always_comb begin
         if (big_ff[j-1]) begin
            take  = ((m_ff[j-1] >> SH) >= LO_LIM);
            ax_in = take ? ax_ff[j-1] >> SH : ax_ff[j-1];
            ay_in = take ? ay_ff[j-1] >> SH : ay_ff[j-1];
            m_in  = take ? m_ff[j-1] >> SH : m_ff[j-1];
         end else begin
            take  = ({1'b0, m_ff[j-1]} < ((NW+1)'(1) << (31 - SH)));
            ax_in = take ? ax_ff[j-1] << SH : ax_ff[j-1];
            ay_in = take ? ay_ff[j-1] << SH : ay_ff[j-1];
            m_in  = take ? m_ff[j-1] << SH : m_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nctl_ff[j].vld <= 1'b0;
            nctl_ff[j].err <= ERR_OK;
         end else begin
            nctl_ff[j] <= nctl_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         ax_ff[j]  <= ax_in;
         ay_ff[j]  <= ay_in;
         m_ff[j]   <= m_in;
         sx_ff[j]  <= sx_ff[j-1];
         sy_ff[j]  <= sy_ff[j-1];
         big_ff[j] <= big_ff[j-1];
         ntx_ff[j] <= ntx_ff[j-1];
         nty_ff[j] <= nty_ff[j-1];
      end
   end

   // back to signed; magnitudes now below 2^31
   ctl_type              octl_ff;
   logic signed [VW-1:0] x0_ff, y0_ff;
   logic [VW-1:0]        axw, ayw;
   logic                 mz_ff;
   logic [W-1:0]         otx_ff, oty_ff;

   always_comb begin
      axw = {1'b0, ax_ff[NS][VW-2:0]};
      ayw = {1'b0, ay_ff[NS][VW-2:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octl_ff.vld <= 1'b0;
         octl_ff.err <= ERR_OK;
      end else begin
         octl_ff <= nctl_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      x0_ff  <= sx_ff[NS] ? VW'(0) - axw : axw;
      y0_ff  <= sy_ff[NS] ? VW'(0) - ayw : ayw;
      mz_ff  <= (m_ff[NS] == '0);
      otx_ff <= ntx_ff[NS];
      oty_ff <= nty_ff[NS];
   end

   assign out_ctl   = octl_ff;
   assign out_x0    = x0_ff;
   assign out_y0    = y0_ff;
   assign out_mzero = mz_ff;
   assign out_tx    = otx_ff;
   assign out_ty    = oty_ff;
endmodule

// File: rtl/rto_cordic.sv
// Pipelined CORDIC vectoring, one micro-rotation per stage
module rto_cordic import rto_pkg::*; #(
   parameter int W = WORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               in_ctl,
   input  logic signed [VW-1:0]  in_x0,
   input  logic signed [VW-1:0]  in_y0,
   input  logic                  in_mzero,
   input  logic [W-1:0]          in_tx,
   input  logic [W-1:0]          in_ty,
   output ctl_type               out_ctl,
   output logic signed [CW-1:0]  out_x,
   output logic signed [CW-1:0]  out_z,
   output logic signed [VW-1:0]  out_x0,
   output logic signed [VW-1:0]  out_y0,
   output logic                  out_mzero,
   output logic [W-1:0]          out_tx,
   output logic [W-1:0]          out_ty
);
   localparam int NS = CORDIC_STEPS;

   ctl_type               ctl_ff [NS+1];
   logic signed [CW-1:0]  cx_ff  [NS+1];
   logic signed [CW-1:0]  cy_ff  [NS+1];
   logic signed [CW-1:0]  cz_ff  [NS+1];
   logic signed [VW-1:0]  x0_ff  [NS+1];
   logic signed [VW-1:0]  y0_ff  [NS+1];
   logic                  mz_ff  [NS+1];
   logic [W-1:0]          tx_ff  [NS+1];
   logic [W-1:0]          ty_ff  [NS+1];

   logic signed [CW-1:0]  px_in, py_in, pz_in, xe, ye;

   // left half plane: rotate by pi first
   always_comb begin
      xe = CW'(in_x0);
      ye = CW'(in_y0);
      if (in_x0 < 0) begin
         pz_in = (in_y0 >= 0) ? PI_Q30 : -PI_Q30;
         px_in = -xe;
         py_in = -ye;
      end else begin
         pz_in = '0;
         px_in = xe;
         py_in = ye;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].vld <= 1'b0;
         ctl_ff[0].err <= ERR_OK;
      end else begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff[0] <= px_in;
      cy_ff[0] <= py_in;
      cz_ff[0] <= pz_in;
      x0_ff[0] <= in_x0;
      y0_ff[0] <= in_y0;
      mz_ff[0] <= in_mzero;
      tx_ff[0] <= in_tx;
      ty_ff[0] <= in_ty;
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
      logic signed [CW-1:0] dx, dy, x_in, y_in, z_in;

      always_comb begin
         dx = cy_ff[i] >>> i;
         dy = cx_ff[i] >>> i;
         if (cy_ff[i] > 0) begin
            x_in = cx_ff[i] + dx;
            y_in = cy_ff[i] - dy;
            z_in = cz_ff[i] + ATAN;
         end else begin
            x_in = cx_ff[i] - dx;
            y_in = cy_ff[i] + dy;
            z_in = cz_ff[i] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1].vld <= 1'b0;
            ctl_ff[i+1].err <= ERR_OK;
         end else begin
            ctl_ff[i+1] <= ctl_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         cx_ff[i+1] <= x_in;
         cy_ff[i+1] <= y_in;
         cz_ff[i+1] <= z_in;
         x0_ff[i+1] <= x0_ff[i];
         y0_ff[i+1] <= y0_ff[i];
         mz_ff[i+1] <= mz_ff[i];
         tx_ff[i+1] <= tx_ff[i];
         ty_ff[i+1] <= ty_ff[i];
      end
   end

   assign out_ctl   = ctl_ff[NS];
   assign out_x     = cx_ff[NS];
   assign out_z     = cz_ff[NS];
   assign out_x0    = x0_ff[NS];
   assign out_y0    = y0_ff[NS];
   assign out_mzero = mz_ff[NS];
   assign out_tx    = tx_ff[NS];
   assign out_ty    = ty_ff[NS];
endmodule

// File: rtl/rto_ratio.sv
// Gain correction, cos/sin division, angle rounding and result register
module rto_ratio import rto_pkg::*; #(
   parameter int W = WORD_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               in_ctl,
   input  logic signed [CW-1:0]  in_x,
   input  logic signed [CW-1:0]  in_z,
   input  logic signed [VW-1:0]  in_x0,
   input  logic signed [VW-1:0]  in_y0,
   input  logic                  in_mzero,
   input  logic [W-1:0]          in_tx,
   input  logic [W-1:0]          in_ty,
   output ctl_type               out_ctl,
   output logic signed [F+1:0]   out_cos,
   output logic signed [F+1:0]   out_sin,
   output logic signed [W-1:0]   out_tx,
   output logic signed [W-1:0]   out_ty,
   output logic signed [F+2:0]   out_angle
);
   localparam int QB  = F + 2;
   localparam int ASH = 30 - F;
   localparam logic signed [CW-1:0] HALF = CW'(1) << (ASH - 1);
   localparam logic signed [CW-1:0] PIF  = (PI_Q30 + HALF) >>> ASH;
   localparam logic [QB-1:0] ONE = QB'(1) << F;

   // stage A: magnitude product and rounded angle
   ctl_type               actl_ff;
   logic signed [63:0]    prod_ff, prod_in;
   logic signed [CW-1:0]  zr, ang;
   logic [F+2:0]          aang_ff;
   logic signed [VW-1:0]  ax0_ff, ay0_ff;
   logic                  amz_ff;
   logic [W-1:0]          atx_ff, aty_ff;

   always_comb begin
      prod_in = in_x * $signed({1'b0, KINV_Q30});
      zr      = in_z + HALF;
      ang     = zr >>> ASH;
      if (ang > PIF) begin
         ang = PIF;
      end else if (ang < -PIF) begin
         ang = -PIF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         actl_ff.vld <= 1'b0;
         actl_ff.err <= ERR_OK;
      end else begin
         actl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      aang_ff <= ang[F+2:0];
      ax0_ff  <= in_x0;
      ay0_ff  <= in_y0;
      amz_ff  <= in_mzero;
      atx_ff  <= in_tx;
      aty_ff  <= in_ty;
   end

   // divider: lane 0 cosine, lane 1 sine
   ctl_type                 rctl_ff [QB+1];
   logic [MAG_W-1:0]        rmag_ff [QB+1];
   logic [1:0][QB-1:0]      rnq_ff  [QB+1];
   logic [1:0][MAG_W-1:0]   rrem_ff [QB+1];
   logic [1:0]              rneg_ff [QB+1];
   logic [F+2:0]            rang_ff [QB+1];
   logic                    rmz_ff  [QB+1];
   logic [W-1:0]            rtx_ff  [QB+1];
   logic [W-1:0]            rty_ff  [QB+1];

   logic signed [63:0]      mg;
   logic [MAG_W-1:0]        mag_in;
   logic [VW-1:0]           abx, aby;

   always_comb begin
      mg     = prod_ff >>> 30;
      mag_in = (mg <= 0) ? MAG_W'(1) : mg[MAG_W-1:0];
      abx    = ax0_ff[VW-1] ? VW'(0) - ax0_ff : ax0_ff;
      aby    = ay0_ff[VW-1] ? VW'(0) - ay0_ff : ay0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rctl_ff[0].vld <= 1'b0;
         rctl_ff[0].err <= ERR_OK;
      end else begin
         rctl_ff[0] <= actl_ff;
      end
   end

   // magnitude stays above 2^29, so the quotient fits in F+2 bits
   always_ff @(posedge clock) begin
      rmag_ff[0]    <= mag_in;
      rnq_ff[0][0]  <= {abx[1:0], {F{1'b0}}};
      rnq_ff[0][1]  <= {aby[1:0], {F{1'b0}}};
      rrem_ff[0][0] <= MAG_W'(abx >> 2);
      rrem_ff[0][1] <= MAG_W'(aby >> 2);
      rneg_ff[0]    <= {ay0_ff[VW-1], ax0_ff[VW-1]};
      rang_ff[0]    <= aang_ff;
      rmz_ff[0]     <= amz_ff;
      rtx_ff[0]     <= atx_ff;
      rty_ff[0]     <= aty_ff;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_stg
      logic [1:0][MAG_W:0]   trial;
      logic [1:0][QB-1:0]    nq_in;
      logic [1:0][MAG_W-1:0] rem_in;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {rrem_ff[k-1][l], rnq_ff[k-1][l][QB-1]};
            if (trial[l] >= {1'b0, rmag_ff[k-1]}) begin
               rem_in[l] = MAG_W'(trial[l] - {1'b0, rmag_ff[k-1]});
               nq_in[l]  = {rnq_ff[k-1][l][QB-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][MAG_W-1:0];
               nq_in[l]  = {rnq_ff[k-1][l][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rctl_ff[k].vld <= 1'b0;
            rctl_ff[k].err <= ERR_OK;
         end else begin
            rctl_ff[k] <= rctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         rmag_ff[k] <= rmag_ff[k-1];
         rnq_ff[k]  <= nq_in;
         rrem_ff[k] <= rem_in;
         rneg_ff[k] <= rneg_ff[k-1];
         rang_ff[k] <= rang_ff[k-1];
         rmz_ff[k]  <= rmz_ff[k-1];
         rtx_ff[k]  <= rtx_ff[k-1];
         rty_ff[k]  <= rty_ff[k-1];
      end
   end

   // clamp to unit, apply sign, blank on error
   ctl_type         octl_ff;
   logic [QB-1:0]   cos_ff, sin_ff, cos_in, sin_in, qc, qs;
   logic [F+2:0]    ang_ff, ang_in;
   logic [W-1:0]    tx_ff, ty_ff, tx_in, ty_in;
   logic            good;

   always_comb begin
      qc     = (rnq_ff[QB][0] > ONE) ? ONE : rnq_ff[QB][0];
      qs     = (rnq_ff[QB][1] > ONE) ? ONE : rnq_ff[QB][1];
      good   = (rctl_ff[QB].err == ERR_OK) && !rmz_ff[QB];
      cos_in = !good ? '0 : (rneg_ff[QB][0] ? QB'(0) - qc : qc);
      sin_in = !good ? '0 : (rneg_ff[QB][1] ? QB'(0) - qs : qs);
      ang_in = good ? rang_ff[QB] : '0;
      tx_in  = (rctl_ff[QB].err == ERR_SCALE) ? '0 : rtx_ff[QB];
      ty_in  = (rctl_ff[QB].err == ERR_SCALE) ? '0 : rty_ff[QB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octl_ff.vld <= 1'b0;
         octl_ff.err <= ERR_OK;
      end else begin
         octl_ff <= rctl_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      ang_ff <= ang_in;
      tx_ff  <= tx_in;
      ty_ff  <= ty_in;
   end

   assign out_ctl   = octl_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_angle = ang_ff;
   assign out_tx    = tx_ff;
   assign out_ty    = ty_ff;
endmodule
